// ===== design/decision_tree_classifier_macros.svh =====
// Assertion macros shared by the decision tree classifier.
`ifndef DECISION_TREE_CLASSIFIER_MACROS_SVH
`define DECISION_TREE_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dtc_pkg.sv =====
// Types and constants shared by the decision tree classifier modules.
package dtc_pkg;

	// Operation codes carried by an input transaction.
	typedef enum logic [1:0] {
		OP_WRITE    = 2'd0,
		OP_CLASSIFY = 2'd1,
		OP_CLEAR    = 2'd2
	} op_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_TREE     = 2'd1,
		ST_BAD_FEATURE = 2'd2,
		ST_STEP_LIMIT  = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	// Class value given when there is no valid answer.
	localparam logic signed [8:0] CLASS_NONE = -9'sd1;

	// Width of one stored tree node.
	localparam int NODE_W = 45;

	// One entry of the node table.
	typedef struct packed {
		logic signed [8:0] first;
		logic signed [8:0] second;
		logic signed [8:0] cls;
		logic [7:0]        left;
		logic              left_p;
		logic [7:0]        right;
		logic              right_p;
	} node_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic node_wr;
		logic root_clr;
		logic start;
		logic rd_en;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic done;
	} sts_t;

endpackage

// ===== design/dtc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module dtc_ram #(
	parameter int WIDTH = 45,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== design/dtc_ctrl.sv =====
// Controller state machine for the decision tree classifier.
module dtc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    operation,
	output logic          out_valid,
	input  logic          out_ready,
	input  dtc_pkg::sts_t sts,
	output dtc_pkg::cmd_t cmd
);
	import dtc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (operation)
						OP_WRITE: begin
							cmd.node_wr = 1'b1;
						end
						OP_CLASSIFY: begin
							cmd.start = 1'b1;
							cmd.rd_en = 1'b1;
							state_d   = S_WALK;
						end
						OP_CLEAR: begin
							cmd.root_clr = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				if (sts.done) begin
					// Finish once the output register can take the result.
					if (!out_valid_q || out_ready) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output transaction valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== design/dtc_dp.sv =====
// Datapath of the decision tree classifier: node table, walk logic and result register.
module dtc_dp #(
	parameter int MAX_NODES = 256,
	parameter int FEATURES  = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dtc_pkg::cmd_t           cmd,
	output dtc_pkg::sts_t           sts,
	input  logic                    cfg_wr,
	input  logic [6:0]              cfg_data,
	input  logic [7:0]              node_index,
	input  logic signed [8:0]       split_first,
	input  logic signed [8:0]       split_second,
	input  logic signed [8:0]       node_class,
	input  logic [7:0]              left_index,
	input  logic                    left_present,
	input  logic [7:0]              right_index,
	input  logic                    right_present,
	input  logic [63:0]             features,
	output logic signed [8:0]       class_out,
	output logic [1:0]              status
);
	import dtc_pkg::*;

	localparam int          AddrW    = $clog2(MAX_NODES);
	localparam int          StepW    = $clog2(MAX_NODES + 1);
	localparam logic [63:0] FeatMask = ~64'd0 >> (64 - FEATURES);
	localparam logic [6:0]  FeatCnt  = 7'(FEATURES);

	logic [6:0]        fcount_q;
	logic              root_loaded_q;
	logic              at_root_q;
	logic [StepW-1:0]  steps_q;
	logic [63:0]       feat_q;
	logic [6:0]        count_q;
	logic signed [8:0] class_q;
	status_t           status_q;

	node_t             wr_node;
	logic              wr_in_range;
	logic [NODE_W-1:0] rd_raw;
	node_t             cur;
	logic [AddrW-1:0]  rd_addr;
	logic [AddrW-1:0]  next_addr;
	logic              test;
	logic              second_ok;
	logic              child_ok;
	logic [7:0]        child_idx;
	logic signed [8:0] res_cls;
	status_t           res_st;
	logic              done;

	// Node write packing and range check.
	always_comb begin
		wr_node.first   = split_first;
		wr_node.second  = split_second;
		wr_node.cls     = node_class;
		wr_node.left    = left_index;
		wr_node.left_p  = left_present;
		wr_node.right   = right_index;
		wr_node.right_p = right_present;
		wr_in_range     = 32'(node_index) < 32'(MAX_NODES);
	end

	assign rd_addr = cmd.start ? '0 : next_addr;

	dtc_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.node_wr && wr_in_range),
		.wr_addr(AddrW'(node_index)),
		.wr_data(wr_node),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign cur = node_t'(rd_raw);

	// Configuration register and root flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q      <= 7'd64;
			root_loaded_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				fcount_q <= cfg_data;
			end
			if (cmd.node_wr && node_index == 8'd0) begin
				root_loaded_q <= 1'b1;
			end else if (cmd.root_clr) begin
				root_loaded_q <= 1'b0;
			end
		end
	end

	// Walk bookkeeping: step count and root marker.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q   <= '0;
			at_root_q <= 1'b0;
		end else if (cmd.start) begin
			steps_q   <= '0;
			at_root_q <= 1'b1;
		end else if (cmd.rd_en) begin
			steps_q   <= steps_q + 1'b1;
			at_root_q <= 1'b0;
		end
	end

	// Feature vector and effective feature count for the current walk.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			feat_q  <= features & FeatMask;
			count_q <= (fcount_q > FeatCnt) ? FeatCnt : fcount_q;
		end
	end

	// Node test and child selection.
	always_comb begin
		second_ok = !cur.second[8] && ({1'b0, cur.second[7:0]} < {2'b00, count_q});
		test      = feat_q[cur.first[5:0]] && (!second_ok || feat_q[cur.second[5:0]]);
		child_idx = test ? cur.right : cur.left;
		child_ok  = (test ? cur.right_p : cur.left_p) && (32'(child_idx) < 32'(MAX_NODES));
		next_addr = AddrW'(child_idx);
	end

	// Walk termination and result.
	always_comb begin
		done    = 1'b1;
		res_cls = cur.cls;
		res_st  = ST_OK;
		priority if (!root_loaded_q) begin
			res_cls = CLASS_NONE;
			res_st  = ST_NO_TREE;
		end else if (at_root_q && !cur.left_p && !cur.right_p) begin
			res_cls = cur.cls;
		end else if (cur.first[8]) begin
			res_cls = cur.cls;
		end else if (steps_q >= StepW'(MAX_NODES)) begin
			res_cls = CLASS_NONE;
			res_st  = ST_STEP_LIMIT;
		end else if ({1'b0, cur.first[7:0]} >= {2'b00, count_q}) begin
			res_cls = CLASS_NONE;
			res_st  = ST_BAD_FEATURE;
		end else if (!child_ok) begin
			res_cls = cur.cls;
		end else begin
			done = 1'b0;
		end
		sts.done = done;
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			class_q  <= res_cls;
			status_q <= res_st;
		end
	end

	assign class_out = class_q;
	assign status    = status_q;

endmodule

// ===== design/decision_tree_classifier.sv =====
// Top level of the decision tree classifier: controller and datapath.
// A classify transaction keeps the input closed while the walk reads the node table,
// one node per cycle, and until the output register is free to take its result.
// Node writes, clears and unused codes are taken while idle and give no result.
// Reset clears the controller, the output valid flag, the root flag and sets
// feature_count to 64; the node table is not cleared and is undefined until written.
`include "decision_tree_classifier_macros.svh"

module decision_tree_classifier #(
	parameter int MAX_NODES = 256,
	parameter int FEATURES  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [7:0]        node_index,
	input  logic signed [8:0] split_first,
	input  logic signed [8:0] split_second,
	input  logic signed [8:0] node_class,
	input  logic [7:0]        left_index,
	input  logic              left_present,
	input  logic [7:0]        right_index,
	input  logic              right_present,
	input  logic [63:0]       features,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [8:0] class_out,
	output logic [1:0]        status
);
	import dtc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The configuration register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	dtc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dtc_dp #(
		.MAX_NODES(MAX_NODES),
		.FEATURES (FEATURES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.node_index   (node_index),
		.split_first  (split_first),
		.split_second (split_second),
		.node_class   (node_class),
		.left_index   (left_index),
		.left_present (left_present),
		.right_index  (right_index),
		.right_present(right_present),
		.features     (features),
		.class_out    (class_out),
		.status       (status)
	);

	// A classify transaction keeps the input closed while the walk runs.
	`DTC_ASSERT_NEXT(a_busy_after_classify, in_valid && in_ready && operation == OP_CLASSIFY, !in_ready, "input accepted during a walk")
	// Any error status carries the no-answer class.
	`DTC_ASSERT_NOW(a_error_class, out_valid && status != ST_OK, class_out == CLASS_NONE, "error result with a class")
	// A node write never coincides with a table read.
	`DTC_ASSERT_NOW(a_no_wr_rd, cmd.node_wr, !cmd.rd_en, "node write during a table read")

endmodule

// ===== sim/decision_tree_classifier_tb.sv =====
// Self-checking testbench for the decision tree classifier: tree loads, walks and feature counts.
module decision_tree_classifier_tb;
	import dtc_pkg::*;

	localparam int MAX_NODES = 256;
	localparam int FEATURES = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Two copies of the tree state: one that plans stimulus, one that checks results.
	localparam int PLAN = 0;
	localparam int LIVE = 1;

	localparam int IDLE_PCT = 12;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int DRAIN_CYCLES = 300;

	// One input transaction as the testbench keeps it.
	typedef struct {
		logic [1:0]  op;
		logic [7:0]  idx;
		node_t       node;
		logic [63:0] vec;
	} tree_req_t;

	// One expected classification.
	typedef struct {
		logic signed [8:0] cls;
		status_t           st;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [6:0]        cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        operation = '0;
	logic [7:0]        node_index = '0;
	logic signed [8:0] split_first = '0;
	logic signed [8:0] split_second = '0;
	logic signed [8:0] node_class = '0;
	logic [7:0]        left_index = '0;
	logic              left_present = 1'b0;
	logic [7:0]        right_index = '0;
	logic              right_present = 1'b0;
	logic [63:0]       features = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic signed [8:0] class_out;
	logic [1:0]        status;

	// Tree state, configuration and bookkeeping.
	node_t     node_mem[2][MAX_NODES];
	bit        node_written[2][MAX_NODES];
	bit        root_valid[2];
	int        feat_count[2] = '{64, 64};
	tree_req_t queued_requests[$];
	answer_t   expected_answers[$];
	tree_req_t next_req;
	tree_req_t seen_req;
	answer_t   want;
	logic signed [8:0] walk_cls;
	status_t   walk_st;
	int        walk_miss;
	int        answers_owed = 0;
	int        errors = 0;
	bit        in_taken = 1'b0;
	bit        calm = 1'b0;
	int        holdoff_asked = 0;
	int        holdoff_done = 0;
	int        holdoff_left = 0;

	decision_tree_classifier i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.node_index(node_index),
		.split_first(split_first),
		.split_second(split_second),
		.node_class(node_class),
		.left_index(left_index),
		.left_present(left_present),
		.right_index(right_index),
		.right_present(right_present),
		.features(features),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.class_out(class_out),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Walk the tree of one side over a feature vector. Returns the index of an
	// entry that the walk would read before it was ever written, or -1 when the
	// walk completes and cls/st hold the answer.
	function automatic int tree_walk(input int side, input logic [63:0] vec,
			output logic signed [8:0] cls, output status_t st);
		int  count;
		int  steps;
		int  f;
		int  s;
		int  nxt;
		bit  test;
		node_t n;
		count = feat_count[side] > FEATURES ? FEATURES : feat_count[side];
		cls = CLASS_NONE;
		st = ST_OK;
		if (!root_valid[side]) begin
			st = ST_NO_TREE;
			return -1;
		end
		n = node_mem[side][0];
		// A root with no children answers with its own class.
		if (!n.left_p && !n.right_p) begin
			cls = n.cls;
			return -1;
		end
		steps = 0;
		f = $signed(n.first);
		while (f >= 0) begin
			if (steps >= MAX_NODES) begin
				st = ST_STEP_LIMIT;
				return -1;
			end
			steps++;
			if (f >= count) begin
				st = ST_BAD_FEATURE;
				return -1;
			end
			// The second feature only counts when it lies inside the valid range.
			s = $signed(n.second);
			test = vec[f];
			if (s >= 0 && s < count)
				test = test && vec[s];
			if (test ? !n.right_p : !n.left_p) begin
				cls = n.cls;
				return -1;
			end
			nxt = test ? n.right : n.left;
			if (!node_written[side][nxt])
				return nxt;
			n = node_mem[side][nxt];
			f = $signed(n.first);
		end
		cls = n.cls;
		return -1;
	endfunction

	// State change caused by one transaction.
	function automatic void apply_item(input int side, input tree_req_t r);
		case (r.op)
			OP_WRITE: begin
				node_mem[side][r.idx] = r.node;
				node_written[side][r.idx] = 1'b1;
				if (r.idx == 8'd0)
					root_valid[side] = 1'b1;
			end
			OP_CLEAR: begin
				root_valid[side] = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic node_t mk_node(input int first, input int second, input int cls,
			input int left, input bit lp, input int right, input bit rp);
		node_t n;
		n.first = 9'(first);
		n.second = 9'(second);
		n.cls = 9'(cls);
		n.left = 8'(left);
		n.left_p = lp;
		n.right = 8'(right);
		n.right_p = rp;
		return n;
	endfunction

	// Random node, mostly with splits that are valid for the planned feature count.
	function automatic node_t random_node();
		int eff;
		int pick;
		int f;
		int s;
		int c;
		int l;
		int r;
		eff = feat_count[PLAN] > FEATURES ? FEATURES : feat_count[PLAN];
		if (eff == 0)
			eff = 1;
		pick = $urandom_range(99);
		if (pick < 20)
			f = -1;
		else if (pick < 24)
			f = -int'($urandom_range(256, 2));
		else if (pick < 30)
			f = $urandom_range(255, eff);
		else
			f = $urandom_range(eff - 1, 0);
		pick = $urandom_range(99);
		if (pick < 40)
			s = -1;
		else if (pick < 50)
			s = -int'($urandom_range(256, 2));
		else if (pick < 60)
			s = $urandom_range(255, eff);
		else
			s = $urandom_range(eff - 1, 0);
		c = ($urandom_range(99) < 10) ? -1 : $urandom_range(511);
		l = ($urandom_range(99) < 60) ? $urandom_range(15) : $urandom_range(255);
		r = ($urandom_range(99) < 60) ? $urandom_range(15) : $urandom_range(255);
		return mk_node(f, s, c, l, $urandom_range(99) < 85, r, $urandom_range(99) < 85);
	endfunction

	function automatic tree_req_t random_req();
		tree_req_t r;
		r.op = 2'($urandom_range(3));
		r.idx = 8'($urandom);
		r.node = 45'({$urandom, $urandom});
		r.vec = {$urandom, $urandom};
		return r;
	endfunction

	function automatic logic [63:0] random_features();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic plan(input tree_req_t r);
		apply_item(PLAN, r);
		queued_requests.insert(queued_requests.size(), r);
	endtask

	task automatic plan_op(input logic [1:0] op);
		tree_req_t r;
		r = random_req();
		r.op = op;
		plan(r);
	endtask

	task automatic plan_write(input logic [7:0] idx, input node_t n);
		tree_req_t r;
		r = random_req();
		r.op = OP_WRITE;
		r.idx = idx;
		r.node = n;
		plan(r);
	endtask

	// Before a classification, load every entry its walk would reach unwritten.
	task automatic plan_classify(input logic [63:0] vec);
		tree_req_t r;
		int miss;
		logic signed [8:0] c;
		status_t s;
		miss = tree_walk(PLAN, vec, c, s);
		while (miss >= 0) begin
			plan_write(8'(miss), random_node());
			miss = tree_walk(PLAN, vec, c, s);
		end
		r = random_req();
		r.op = OP_CLASSIFY;
		r.vec = vec;
		plan(r);
	endtask

	// Mostly tree edits and classifications, with clears and unused codes mixed in.
	task automatic random_phase(input int count);
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (!root_valid[PLAN] && pick < 50)
				plan_write(8'd0, random_node());
			else if (pick < 60)
				plan_classify(random_features());
			else if (pick < 78)
				plan_write(8'($urandom_range(15)), random_node());
			else if (pick < 86)
				plan_write(8'($urandom_range(255)), random_node());
			else if (pick < 92)
				plan_write(8'd0, random_node());
			else if (pick < 95)
				plan_op(OP_CLEAR);
			else if (pick < 97)
				plan_op(OP_UNUSED);
			else
				plan_classify(random_features());
		end
	endtask

	// Wait until every transaction is sent and every result has come back.
	task automatic wait_idle();
		do
			@(posedge clk);
		while (queued_requests.size() != 0 || in_valid || answers_owed != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_feature_count(input int value);
		wait_idle();
		feat_count[PLAN] = value;
		@(negedge clk);
		cfg_data <= 7'(value);
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Input driver: a new transaction only once the previous one was taken.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (queued_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				next_req = queued_requests.pop_front();
				operation <= next_req.op;
				node_index <= next_req.idx;
				split_first <= next_req.node.first;
				split_second <= next_req.node.second;
				node_class <= next_req.node.cls;
				left_index <= next_req.node.left;
				left_present <= next_req.node.left_p;
				right_index <= next_req.node.right;
				right_present <= next_req.node.right_p;
				features <= next_req.vec;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (holdoff_done != holdoff_asked) begin
			holdoff_left = HOLDOFF_CYCLES;
			holdoff_done = holdoff_asked;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Monitor: predict on every accepted transaction, check every accepted result.
	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		if (cfg_valid && cfg_ready)
			feat_count[LIVE] = cfg_data;
		if (in_valid && in_ready) begin
			seen_req.op = operation;
			seen_req.idx = node_index;
			seen_req.node.first = split_first;
			seen_req.node.second = split_second;
			seen_req.node.cls = node_class;
			seen_req.node.left = left_index;
			seen_req.node.left_p = left_present;
			seen_req.node.right = right_index;
			seen_req.node.right_p = right_present;
			seen_req.vec = features;
			if (seen_req.op == OP_CLASSIFY) begin
				walk_miss = tree_walk(LIVE, seen_req.vec, walk_cls, walk_st);
				if (walk_miss >= 0) begin
					$display("%0t: classification reaches unwritten entry %0d", $time, walk_miss);
					errors++;
				end
				want.cls = walk_cls;
				want.st = walk_st;
				expected_answers.insert(expected_answers.size(), want);
			end
			apply_item(LIVE, seen_req);
		end
		if (out_valid && out_ready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: unexpected result, class_out %0d status %0d",
					$time, class_out, status);
				errors++;
			end else begin
				want = expected_answers.pop_front();
				if (class_out !== want.cls) begin
					$display("%0t: class_out expected %0d, got %0d", $time, want.cls, class_out);
					errors++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d, got %0d", $time, want.st, status);
					errors++;
				end
			end
		end
		answers_owed <= expected_answers.size();
	end

	// Stimulus sequence.
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed cases at the reset feature count.
		plan_classify('1);
		plan_op(OP_UNUSED);
		plan_write(8'd0, mk_node(-1, -1, 255, 0, 0, 0, 0));
		plan_classify('0);
		// Root without children, even though its split fields name features.
		plan_write(8'd0, mk_node(5, 7, -256, 3, 0, 4, 0));
		plan_classify('1);
		plan_write(8'd1, mk_node(-1, -1, -1, 0, 0, 0, 0));
		plan_write(8'd2, mk_node(-1, -1, 255, 0, 0, 0, 0));
		plan_write(8'd0, mk_node(63, -1, 7, 1, 1, 2, 1));
		plan_classify(64'd1 << 63);
		plan_classify('0);
		// AND of two features.
		plan_write(8'd0, mk_node(0, 63, 3, 1, 1, 2, 1));
		plan_classify(64'd1);
		plan_classify(64'd1 | (64'd1 << 63));
		// Second feature out of range: the first feature decides alone.
		plan_write(8'd0, mk_node(0, 64, 3, 1, 1, 2, 1));
		plan_classify(64'd1);
		// Missing right child ends the walk with the node's own class.
		plan_write(8'd2, mk_node(1, -256, 44, 1, 1, 200, 0));
		plan_write(8'd0, mk_node(0, -1, 3, 1, 1, 2, 1));
		plan_classify(64'd3);
		plan_classify(64'd1);
		// First feature out of range.
		plan_write(8'd0, mk_node(64, -1, 3, 1, 1, 2, 1));
		plan_classify('1);
		// Root that loops back to itself runs into the step cap.
		plan_write(8'd0, mk_node(0, -1, 3, 0, 1, 0, 1));
		plan_classify(64'd1);
		plan_op(OP_CLEAR);
		plan_classify('1);

		random_phase(120);
		set_feature_count(0);
		random_phase(50);
		set_feature_count(1);
		random_phase(80);
		// Long receiver hold-off while the queue is full, so the input backs up.
		set_feature_count(127);
		holdoff_asked++;
		random_phase(120);
		// A stretch with no idling on either side.
		set_feature_count(64);
		calm = 1'b1;
		random_phase(120);
		wait_idle();
		calm = 1'b0;
		random_phase(60);
		set_feature_count($urandom_range(63, 2));
		random_phase(80);
		set_feature_count($urandom_range(126, 65));
		random_phase(50);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("decision_tree_classifier_tb: clean");
		else
			$display("decision_tree_classifier_tb: errors");
		$finish;
	end

	// Watchdog: a correct run, even with every classification hitting the step cap,
	// ends long before this timeout.
	initial begin
		#20000000;
		$display("decision_tree_classifier_tb: errors");
		$finish;
	end

endmodule
